### hdl/rbwa_pkg.sv
// shared types, constants and arithmetic helpers for the rgb blend pipeline
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package rbwa_pkg;

	localparam int CHAN_W  = 8;
	localparam int PROD_W  = 2 * CHAN_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int MODE_W = 2;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LEVEL = 2'd1;

	// blend modes
	localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MULTIPLY = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SCREEN   = 2'd3;

	localparam logic [MODE_W-1:0]  BLEND_MODE_RST  = MODE_NORMAL;
	localparam logic [CHAN_W-1:0]  ALPHA_LEVEL_RST = 8'd255;

	// stage advance strobes shared by the lanes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

	// exact floor(x / 255) for any x up to 255 * 255
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		begin
			t = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
			div255 = t[PROD_W-1:CHAN_W];
		end
	endfunction

endpackage

### hdl/rbwa_lane.sv
// one color channel of the blend pipeline: mode product, mode select,
// alpha mix and divide by 255; depends on rbwa_pkg
`timescale 1ns / 1ps

module rbwa_lane (
	input  logic                          clk,
	input  rbwa_pkg::adv_t                adv,
	input  logic [rbwa_pkg::MODE_W-1:0]   mode,
	input  logic [rbwa_pkg::CHAN_W-1:0]   alpha,
	input  logic [rbwa_pkg::CHAN_W-1:0]   dst,
	input  logic [rbwa_pkg::CHAN_W-1:0]   src,
	output logic [rbwa_pkg::CHAN_W-1:0]   result
);

	logic [rbwa_pkg::CHAN_W-1:0] op_a, op_b;
	logic [rbwa_pkg::PROD_W-1:0] prod_s1;
	logic [rbwa_pkg::CHAN_W-1:0] dst_s1, src_s1;
	logic [rbwa_pkg::CHAN_W-1:0] blend_c;
	logic [rbwa_pkg::CHAN_W:0]   sum_c;
	logic [rbwa_pkg::CHAN_W-1:0] quot_c;
	logic [rbwa_pkg::CHAN_W-1:0] blend_s2, dst_s2;
	logic [rbwa_pkg::PROD_W-1:0] wsrc_c, wdst_c;
	logic [rbwa_pkg::PROD_W:0]   mix_c;
	logic [rbwa_pkg::PROD_W-1:0] mix_s3;
	logic [rbwa_pkg::CHAN_W-1:0] out_s4;

	// screen works on the inverted channels, multiply on the plain ones
	always_comb begin
		if (mode == rbwa_pkg::MODE_SCREEN) begin
			op_a = rbwa_pkg::CHAN_MAX - dst;
			op_b = rbwa_pkg::CHAN_MAX - src;
		end else begin
			op_a = dst;
			op_b = src;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			prod_s1 <= op_a * op_b;
			dst_s1  <= dst;
			src_s1  <= src;
		end
	end

	always_comb begin
		sum_c  = {1'b0, dst_s1} + {1'b0, src_s1};
		quot_c = rbwa_pkg::div255(prod_s1);
		case (mode)
			rbwa_pkg::MODE_NORMAL:   blend_c = src_s1;
			rbwa_pkg::MODE_ADD:      blend_c = sum_c[rbwa_pkg::CHAN_W] ?
				rbwa_pkg::CHAN_MAX : sum_c[rbwa_pkg::CHAN_W-1:0];
			rbwa_pkg::MODE_MULTIPLY: blend_c = quot_c;
			rbwa_pkg::MODE_SCREEN:   blend_c = rbwa_pkg::CHAN_MAX - quot_c;
			default:                 blend_c = src_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			blend_s2 <= blend_c;
			dst_s2   <= dst_s1;
		end
	end

	// alpha of 255 and 0 fall out of the weighted sum exactly
	always_comb begin
		wsrc_c = blend_s2 * alpha;
		wdst_c = dst_s2 * (rbwa_pkg::CHAN_MAX - alpha);
		mix_c  = {1'b0, wsrc_c} + {1'b0, wdst_c};
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			mix_s3 <= mix_c[rbwa_pkg::PROD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			out_s4 <= rbwa_pkg::div255(mix_s3);
		end
	end

	assign result = out_s4;

endmodule

### hdl/rbwa_pipe_ctrl.sv
// valid tracking and per-stage advance for the four-stage blend pipeline
// depends on rbwa_pkg
`timescale 1ns / 1ps

module rbwa_pipe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output rbwa_pkg::adv_t adv
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		adv.s4 = !vld_s4 || out_ready;
		adv.s3 = !vld_s3 || adv.s4;
		adv.s2 = !vld_s2 || adv.s3;
		adv.s1 = !vld_s1 || adv.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv.s1) vld_s1 <= in_valid;
			if (adv.s2) vld_s2 <= vld_s1;
			if (adv.s3) vld_s3 <= vld_s2;
			if (adv.s4) vld_s4 <= vld_s3;
		end
	end

	assign in_ready  = adv.s1;
	assign out_valid = vld_s4;

endmodule

### hdl/rgb_blend_with_alpha.sv
// top level of the rgb888 blend with alpha: config registers, three channel
// lanes and the pipeline control; depends on rbwa_pkg, rbwa_lane, rbwa_pipe_ctrl
`timescale 1ns / 1ps

// Composites one source pixel onto one destination pixel per transfer. Each
// of the red, green and blue lanes applies the blend mode (normal, saturating
// add, multiply/255, screen) and then mixes with the destination by
// alpha_level, every division by 255 truncating. A pixel is accepted every
// clock cycle unless a stalled output has filled the stages behind it. The
// four stages come from the two 8x8 multiply stages of each lane, each
// followed by a divide by 255. Up to four pixels are in flight and a
// finished pixel waiting at the output does not stop the stages behind it
// from filling. Write blend_mode (index 0) and alpha_level (index 1) only
// while the pipeline is empty.
module rgb_blend_with_alpha (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rbwa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbwa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rbwa_pkg::CHAN_W-1:0]       dst_red,
	input  logic [rbwa_pkg::CHAN_W-1:0]       dst_green,
	input  logic [rbwa_pkg::CHAN_W-1:0]       dst_blue,
	input  logic [rbwa_pkg::CHAN_W-1:0]       src_red,
	input  logic [rbwa_pkg::CHAN_W-1:0]       src_green,
	input  logic [rbwa_pkg::CHAN_W-1:0]       src_blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rbwa_pkg::CHAN_W-1:0]       out_red,
	output logic [rbwa_pkg::CHAN_W-1:0]       out_green,
	output logic [rbwa_pkg::CHAN_W-1:0]       out_blue
);

	logic [rbwa_pkg::MODE_W-1:0] blend_mode_q;
	logic [rbwa_pkg::CHAN_W-1:0] alpha_level_q;
	rbwa_pkg::adv_t              adv;

	// writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q  <= rbwa_pkg::BLEND_MODE_RST;
			alpha_level_q <= rbwa_pkg::ALPHA_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rbwa_pkg::REG_BLEND_MODE:  blend_mode_q  <= cfg_data[rbwa_pkg::MODE_W-1:0];
				rbwa_pkg::REG_ALPHA_LEVEL: alpha_level_q <= cfg_data[rbwa_pkg::CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	rbwa_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.adv       (adv)
	);

	rbwa_lane u_lane_red (
		.clk    (clk),
		.adv    (adv),
		.mode   (blend_mode_q),
		.alpha  (alpha_level_q),
		.dst    (dst_red),
		.src    (src_red),
		.result (out_red)
	);

	rbwa_lane u_lane_green (
		.clk    (clk),
		.adv    (adv),
		.mode   (blend_mode_q),
		.alpha  (alpha_level_q),
		.dst    (dst_green),
		.src    (src_green),
		.result (out_green)
	);

	rbwa_lane u_lane_blue (
		.clk    (clk),
		.adv    (adv),
		.mode   (blend_mode_q),
		.alpha  (alpha_level_q),
		.dst    (dst_blue),
		.src    (src_blue),
		.result (out_blue)
	);

endmodule

### hdl/rbwa_checker.sv
// port-level checks for rgb_blend_with_alpha, attached by bind
// depends on rbwa_pkg and the top level's port list
`timescale 1ns / 1ps

module rbwa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [rbwa_pkg::CHAN_W-1:0]       out_red,
	input logic [rbwa_pkg::CHAN_W-1:0]       out_green,
	input logic [rbwa_pkg::CHAN_W-1:0]       out_blue
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue))
		else $error("output changed while stalled");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("output valid dropped without a transfer");

	// with the output side free every stage can move, so input is open
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked while output side is free");

	// an accepted pixel reaches the output through every stage when the output never stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
			|=> out_valid)
		else $error("result missing four cycles after transfer");

endmodule

bind rgb_blend_with_alpha rbwa_checker u_rbwa_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for rgb_blend_with_alpha: directed corner pixels, then random
// pixels under changing blend settings, with random gaps and stalls on both channels
// depends on rbwa_pkg and the rgb_blend_with_alpha rtl

module testbench;

	// indexes that decode to no register
	localparam logic [rbwa_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [rbwa_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int RANDOM_PIXELS = 650;
	localparam int PHASES        = 13;
	localparam int TAIL_CYCLES   = 12;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [rbwa_pkg::CHAN_W-1:0] r;
		logic [rbwa_pkg::CHAN_W-1:0] g;
		logic [rbwa_pkg::CHAN_W-1:0] b;
	} rgb_t;

	typedef enum logic [1:0] {JOB_PIXEL, JOB_REG_WRITE, JOB_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t                         kind;
		rgb_t                              dst;
		rgb_t                              src;
		logic [rbwa_pkg::CFG_IDX_W-1:0]    idx;
		logic [rbwa_pkg::CFG_DATA_W-1:0]   data;
	} job_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [rbwa_pkg::CFG_IDX_W-1:0]    cfg_index = rbwa_pkg::REG_BLEND_MODE;
	logic [rbwa_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [rbwa_pkg::CHAN_W-1:0]       dst_red = '0;
	logic [rbwa_pkg::CHAN_W-1:0]       dst_green = '0;
	logic [rbwa_pkg::CHAN_W-1:0]       dst_blue = '0;
	logic [rbwa_pkg::CHAN_W-1:0]       src_red = '0;
	logic [rbwa_pkg::CHAN_W-1:0]       src_green = '0;
	logic [rbwa_pkg::CHAN_W-1:0]       src_blue = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [rbwa_pkg::CHAN_W-1:0]       out_red;
	logic [rbwa_pkg::CHAN_W-1:0]       out_green;
	logic [rbwa_pkg::CHAN_W-1:0]       out_blue;

	job_t                              jobs[$];
	rgb_t                              composite_q[$];
	logic [rbwa_pkg::MODE_W-1:0]       cur_mode = rbwa_pkg::BLEND_MODE_RST;
	logic [rbwa_pkg::CHAN_W-1:0]       cur_alpha = rbwa_pkg::ALPHA_LEVEL_RST;
	int                                fault_count = 0;
	bit                                sending_done = 1'b0;
	int                                send_gap = 0;
	int                                send_calm = 0;
	int                                stall_left = 0;
	int                                recv_calm = 0;

	rgb_blend_with_alpha dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dst_red   (dst_red),
		.dst_green (dst_green),
		.dst_blue  (dst_blue),
		.src_red   (src_red),
		.src_green (src_green),
		.src_blue  (src_blue),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue)
	);

	function automatic logic [rbwa_pkg::CHAN_W-1:0] blend_channel(
			input logic [rbwa_pkg::MODE_W-1:0] mode,
			input logic [rbwa_pkg::CHAN_W-1:0] alpha, input logic [rbwa_pkg::CHAN_W-1:0] d,
			input logic [rbwa_pkg::CHAN_W-1:0] s);
		int unsigned dv, sv, av, full, mixed, sum;
		dv = 32'(d);
		sv = 32'(s);
		av = 32'(alpha);
		full = 32'(rbwa_pkg::CHAN_MAX);
		case (mode)
			rbwa_pkg::MODE_ADD: begin
				sum = dv + sv;
				mixed = (sum > full) ? full : sum;
			end
			rbwa_pkg::MODE_MULTIPLY: mixed = (dv * sv) / full;
			rbwa_pkg::MODE_SCREEN:   mixed = full - ((full - dv) * (full - sv)) / full;
			default:                 mixed = sv;
		endcase
		if (av == full)
			return mixed[rbwa_pkg::CHAN_W-1:0];
		if (av == 0)
			return d;
		sum = (mixed * av + dv * (full - av)) / full;
		return sum[rbwa_pkg::CHAN_W-1:0];
	endfunction

	function automatic rgb_t composite_pixel(input rgb_t dst, input rgb_t src);
		rgb_t res;
		res.r = blend_channel(cur_mode, cur_alpha, dst.r, src.r);
		res.g = blend_channel(cur_mode, cur_alpha, dst.g, src.g);
		res.b = blend_channel(cur_mode, cur_alpha, dst.b, src.b);
		return res;
	endfunction

	function automatic void take_register(input logic [rbwa_pkg::CFG_IDX_W-1:0] idx,
			input logic [rbwa_pkg::CFG_DATA_W-1:0] data);
		if (idx == rbwa_pkg::REG_BLEND_MODE)
			cur_mode = data[rbwa_pkg::MODE_W-1:0];
		else if (idx == rbwa_pkg::REG_ALPHA_LEVEL)
			cur_alpha = data[rbwa_pkg::CHAN_W-1:0];
	endfunction

	// mostly no gap, some short ones, a few long ones, and calm stretches
	function automatic int idle_length(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = int'($urandom_range(99));
		if (roll < 5) begin
			calm = int'($urandom_range(40, 10));
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 90)
			return int'($urandom_range(3, 1));
		return int'($urandom_range(30, 6));
	endfunction

	function automatic logic [rbwa_pkg::CHAN_W-1:0] pick_channel();
		int roll;
		roll = int'($urandom_range(7));
		if (roll == 0)
			return '0;
		if (roll == 1)
			return rbwa_pkg::CHAN_MAX;
		return 8'($urandom_range(255));
	endfunction

	function automatic rgb_t pick_rgb();
		rgb_t res;
		res.r = pick_channel();
		res.g = pick_channel();
		res.b = pick_channel();
		return res;
	endfunction

	task automatic queue_pixel(input rgb_t dst, input rgb_t src);
		job_t job;
		job.kind = JOB_PIXEL;
		job.dst = dst;
		job.src = src;
		job.idx = rbwa_pkg::REG_BLEND_MODE;
		job.data = '0;
		jobs.push_back(job);
	endtask

	task automatic queue_write(input logic [rbwa_pkg::CFG_IDX_W-1:0] idx,
			input logic [rbwa_pkg::CFG_DATA_W-1:0] data);
		job_t job;
		job.kind = JOB_REG_WRITE;
		job.dst = '0;
		job.src = '0;
		job.idx = idx;
		job.data = data;
		jobs.push_back(job);
	endtask

	task automatic queue_drain();
		job_t job;
		job.kind = JOB_DRAIN;
		job.dst = '0;
		job.src = '0;
		job.idx = rbwa_pkg::REG_BLEND_MODE;
		job.data = '0;
		jobs.push_back(job);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: pixels go out after random gaps, register writes only with nothing in flight
	always @(posedge clk or negedge arst_n) begin
		job_t job;
		logic held, nxt_valid, nxt_we;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_we <= 1'b0;
			sending_done <= 1'b0;
			send_gap = 0;
		end else begin
			held = in_valid && !in_ready;
			if (in_valid && in_ready)
				composite_q.push_back(composite_pixel({dst_red, dst_green, dst_blue},
					{src_red, src_green, src_blue}));
			nxt_valid = held;
			nxt_we = 1'b0;
			if (!held) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (jobs.size() > 0) begin
					job = jobs[0];
					case (job.kind)
						JOB_PIXEL: begin
							void'(jobs.pop_front());
							{dst_red, dst_green, dst_blue} <= job.dst;
							{src_red, src_green, src_blue} <= job.src;
							nxt_valid = 1'b1;
							send_gap = idle_length(send_calm);
						end
						JOB_REG_WRITE: if (composite_q.size() == 0) begin
							void'(jobs.pop_front());
							cfg_index <= job.idx;
							cfg_data <= job.data;
							nxt_we = 1'b1;
							take_register(job.idx, job.data);
						end
						default: if (composite_q.size() == 0) begin
							void'(jobs.pop_front());
						end
					endcase
				end
			end
			in_valid <= nxt_valid;
			cfg_we <= nxt_we;
			sending_done <= (jobs.size() == 0) && !nxt_valid;
		end
	end

	// monitor: random back-pressure and in-order compare of every output transfer
	always @(posedge clk or negedge arst_n) begin
		rgb_t want, got;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {out_red, out_green, out_blue};
				if (composite_q.size() == 0) begin
					if (fault_count < MAX_REPORTS)
						$display("%0t: unexpected pixel %h %h %h", $realtime,
							got.r, got.g, got.b);
					fault_count++;
				end else begin
					want = composite_q.pop_front();
					if (got.r !== want.r || got.g !== want.g || got.b !== want.b) begin
						if (fault_count < MAX_REPORTS)
							$display({"%0t: pixel mismatch, expected r %h g %h b %h,",
								" got r %h g %h b %h"},
								$realtime, want.r, want.g, want.b, got.r, got.g, got.b);
						fault_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = idle_length(recv_calm);
			end
		end
	end

	initial begin
		logic [rbwa_pkg::CFG_DATA_W-1:0] word;
		int per_phase, cut;
		// reset settings: normal mode, fully opaque
		queue_pixel({8'h00, 8'h00, 8'h00}, {8'hff, 8'hff, 8'hff});
		queue_pixel({8'hff, 8'hff, 8'hff}, {8'h00, 8'h00, 8'h00});
		queue_pixel({8'haa, 8'h55, 8'hff}, {8'h55, 8'haa, 8'h00});
		// writes to undecoded indexes must leave the settings alone
		queue_write(REG_SPARE_2, {6'h3f, rbwa_pkg::MODE_MULTIPLY});
		queue_write(REG_SPARE_3, 8'h00);
		queue_pixel({8'h10, 8'h20, 8'h30}, {8'h40, 8'h50, 8'h60});
		// add, multiply and screen with junk in the upper data bits
		queue_write(rbwa_pkg::REG_BLEND_MODE, {6'h2d, rbwa_pkg::MODE_ADD});
		queue_pixel({8'hff, 8'h80, 8'h00}, {8'hff, 8'h80, 8'h01});
		queue_pixel({8'h01, 8'hfe, 8'h7f}, {8'hff, 8'h02, 8'h80});
		queue_write(rbwa_pkg::REG_BLEND_MODE, {6'h12, rbwa_pkg::MODE_MULTIPLY});
		queue_pixel({8'hff, 8'h80, 8'h00}, {8'hff, 8'h80, 8'h01});
		queue_pixel({8'h01, 8'hfe, 8'h7f}, {8'hff, 8'h02, 8'h80});
		queue_write(rbwa_pkg::REG_BLEND_MODE, {6'h3f, rbwa_pkg::MODE_SCREEN});
		queue_pixel({8'hff, 8'h80, 8'h00}, {8'hff, 8'h80, 8'h01});
		queue_pixel({8'h01, 8'hfe, 8'h7f}, {8'hff, 8'h02, 8'h80});
		// alpha extremes, then half alpha with add and back to normal, fully opaque
		queue_write(rbwa_pkg::REG_ALPHA_LEVEL, 8'h00);
		queue_pixel({8'h12, 8'h34, 8'h56}, {8'hff, 8'hff, 8'hff});
		queue_write(rbwa_pkg::REG_ALPHA_LEVEL, 8'h01);
		queue_pixel({8'hff, 8'h00, 8'h80}, {8'h00, 8'hff, 8'h80});
		queue_write(rbwa_pkg::REG_ALPHA_LEVEL, 8'hfe);
		queue_pixel({8'hff, 8'h00, 8'h80}, {8'h00, 8'hff, 8'h80});
		queue_write(rbwa_pkg::REG_BLEND_MODE, {6'h00, rbwa_pkg::MODE_ADD});
		queue_write(rbwa_pkg::REG_ALPHA_LEVEL, 8'h80);
		queue_pixel({8'hff, 8'hff, 8'h00}, {8'h00, 8'hff, 8'hff});
		queue_write(rbwa_pkg::REG_BLEND_MODE, {6'h00, rbwa_pkg::MODE_NORMAL});
		queue_write(rbwa_pkg::REG_ALPHA_LEVEL, 8'hff);
		queue_pixel({8'h00, 8'hff, 8'h55}, {8'hff, 8'h00, 8'haa});

		per_phase = RANDOM_PIXELS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			word = 8'($urandom_range(255));
			word[rbwa_pkg::MODE_W-1:0] = 2'(ph % 4);
			if ($urandom_range(1))
				queue_write(rbwa_pkg::REG_BLEND_MODE, word);
			case (ph % 5)
				0:       word = 8'h00;
				1:       word = 8'hff;
				2:       word = 8'h01;
				3:       word = 8'hfe;
				default: word = 8'($urandom_range(255));
			endcase
			queue_write(rbwa_pkg::REG_ALPHA_LEVEL, word);
			word = 8'($urandom_range(255));
			word[rbwa_pkg::MODE_W-1:0] = 2'(ph % 4);
			queue_write(rbwa_pkg::REG_BLEND_MODE, word);
			if ($urandom_range(1)) begin
				word = 8'($urandom_range(255));
				queue_write($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, word);
			end
			cut = int'($urandom_range(per_phase - 1, 1));
			for (int i = 0; i < per_phase; i++) begin
				// hold off until the pipe has emptied
				if (i == cut)
					queue_drain();
				queue_pixel(pick_rgb(), pick_rgb());
			end
		end

		do @(posedge clk);
		while (!(sending_done && composite_q.size() == 0));
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0 && composite_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
